@@ sv/dhst_pkg.sv @@
package dhst_pkg;

  localparam logic [15:0] THRESH    = 16'd41;
  localparam logic [16:0] LOG2E_Q16 = 17'd94548;
  localparam int          DIV_STEPS = 21;

  localparam logic CFG_DECAY    = 1'b0;
  localparam logic CFG_FALLBACK = 1'b1;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_PWR, S_TINIT, S_DIV, S_MY, S_MM, S_TWR, S_CNT, S_LOAD, S_SEND
  } state_t;

  typedef struct packed {
    logic capture;
    logic scan_clr;
    logic scan_step;
    logic push_wr;
    logic tick_init;
    logic div_step;
    logic mul_y;
    logic mul_m;
    logic tick_wr;
    logic cnt_clr;
    logic cnt_step;
    logic out_load;
    logic out_push;
    logic out_last;
  } cmd_t;

  typedef struct packed {
    logic skip;
  } sts_t;

  // 2^(-k/16) in Q16
  function automatic logic [16:0] pow2_q16(input logic [4:0] k);
    logic [16:0] v;
    unique case (k)
      5'd0:  v = 17'd65536;
      5'd1:  v = 17'd62757;
      5'd2:  v = 17'd60097;
      5'd3:  v = 17'd57549;
      5'd4:  v = 17'd55109;
      5'd5:  v = 17'd52773;
      5'd6:  v = 17'd50535;
      5'd7:  v = 17'd48393;
      5'd8:  v = 17'd46341;
      5'd9:  v = 17'd44376;
      5'd10: v = 17'd42495;
      5'd11: v = 17'd40693;
      5'd12: v = 17'd38968;
      5'd13: v = 17'd37317;
      5'd14: v = 17'd35734;
      5'd15: v = 17'd34219;
      default: v = 17'd32768;
    endcase
    return v;
  endfunction

endpackage

@@ sv/dhst_ctrl.sv @@
module dhst_ctrl #(
  parameter int SLOTS = 8,
  parameter int IW    = 3
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  input  logic            in_op,
  output logic            in_tready,
  output logic            out_tvalid,
  input  logic            out_tready,
  input  dhst_pkg::sts_t  sts,
  output dhst_pkg::cmd_t  cmd,
  output logic [IW-1:0]   idx
);

  localparam logic [IW-1:0] LAST_IDX  = IW'(SLOTS - 1);
  localparam logic [4:0]    LAST_STEP = 5'(dhst_pkg::DIV_STEPS - 1);

  dhst_pkg::state_t state_r, state_nxt;
  logic [IW-1:0]    idx_r, idx_nxt;
  logic [4:0]       step_r, step_nxt;
  logic             op_r, op_nxt;
  logic             at_last;
  logic             accept;

  assign at_last   = (idx_r == LAST_IDX);
  assign accept    = in_tvalid && (state_r == dhst_pkg::S_IDLE);
  assign in_tready = (state_r == dhst_pkg::S_IDLE);
  assign out_tvalid = (state_r == dhst_pkg::S_SEND);
  assign idx       = idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dhst_pkg::S_IDLE;
      idx_r   <= '0;
      step_r  <= '0;
      op_r    <= dhst_pkg::OP_PUSH;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      step_r  <= step_nxt;
      op_r    <= op_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    step_nxt  = step_r;
    op_nxt    = op_r;
    unique case (state_r)
      dhst_pkg::S_IDLE: begin
        if (in_tvalid) begin
          op_nxt    = in_op;
          idx_nxt   = '0;
          state_nxt = (in_op == dhst_pkg::OP_TICK) ? dhst_pkg::S_TINIT : dhst_pkg::S_SCAN;
        end
      end
      dhst_pkg::S_SCAN: begin
        if (at_last) state_nxt = dhst_pkg::S_PWR;
        else idx_nxt = idx_r + 1'b1;
      end
      dhst_pkg::S_PWR: begin
        idx_nxt   = '0;
        state_nxt = dhst_pkg::S_CNT;
      end
      dhst_pkg::S_TINIT: begin
        step_nxt = '0;
        if (!sts.skip) state_nxt = dhst_pkg::S_DIV;
        else if (at_last) begin
          idx_nxt   = '0;
          state_nxt = dhst_pkg::S_CNT;
        end else idx_nxt = idx_r + 1'b1;
      end
      dhst_pkg::S_DIV: begin
        step_nxt = step_r + 1'b1;
        if (step_r == LAST_STEP) state_nxt = dhst_pkg::S_MY;
      end
      dhst_pkg::S_MY: state_nxt = dhst_pkg::S_MM;
      dhst_pkg::S_MM: state_nxt = dhst_pkg::S_TWR;
      dhst_pkg::S_TWR: begin
        if (at_last) begin
          idx_nxt   = '0;
          state_nxt = dhst_pkg::S_CNT;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = dhst_pkg::S_TINIT;
        end
      end
      dhst_pkg::S_CNT: begin
        if (at_last) begin
          idx_nxt   = '0;
          state_nxt = dhst_pkg::S_LOAD;
        end else idx_nxt = idx_r + 1'b1;
      end
      dhst_pkg::S_LOAD: state_nxt = dhst_pkg::S_SEND;
      dhst_pkg::S_SEND: begin
        if (out_tready) begin
          if (op_r == dhst_pkg::OP_PUSH || at_last) state_nxt = dhst_pkg::S_IDLE;
          else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = dhst_pkg::S_LOAD;
          end
        end
      end
      default: state_nxt = dhst_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.capture   = accept;
    cmd.scan_clr  = accept;
    cmd.out_push  = (op_r == dhst_pkg::OP_PUSH);
    cmd.out_last  = (op_r == dhst_pkg::OP_PUSH) || at_last;
    unique case (state_r)
      dhst_pkg::S_SCAN:  cmd.scan_step = 1'b1;
      dhst_pkg::S_PWR: begin
        cmd.push_wr = 1'b1;
        cmd.cnt_clr = 1'b1;
      end
      dhst_pkg::S_TINIT: begin
        cmd.tick_init = 1'b1;
        cmd.cnt_clr   = 1'b1;
      end
      dhst_pkg::S_DIV:   cmd.div_step = 1'b1;
      dhst_pkg::S_MY:    cmd.mul_y    = 1'b1;
      dhst_pkg::S_MM:    cmd.mul_m    = 1'b1;
      dhst_pkg::S_TWR: begin
        cmd.tick_wr = 1'b1;
        cmd.cnt_clr = 1'b1;
      end
      dhst_pkg::S_CNT:   cmd.cnt_step = 1'b1;
      dhst_pkg::S_LOAD:  cmd.out_load = 1'b1;
      default: ;
    endcase
  end

endmodule

@@ sv/dhst_dp.sv @@
module dhst_dp #(
  parameter int SLOTS = 8,
  parameter int IW    = 3
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic            cfg_addr,
  input  logic [31:0]     cfg_wdata,
  input  logic [183:0]    in_tdata,
  input  dhst_pkg::cmd_t  cmd,
  input  logic [IW-1:0]   idx,
  output dhst_pkg::sts_t  sts,
  output logic [167:0]    out_tdata,
  output logic            out_tuser,
  output logic            out_tlast
);

  logic [15:0] decay_r;
  logic [31:0] fallback_r;

  logic [15:0] start_lv_r [SLOTS];
  logic [15:0] cur_lv_r   [SLOTS];
  logic [31:0] st_time_r  [SLOTS];
  logic [31:0] col_r      [SLOTS];
  logic [31:0] px_r       [SLOTS];
  logic [31:0] py_r       [SLOTS];
  logic [31:0] pz_r       [SLOTS];
  logic [7:0]  tex_r      [SLOTS];

  logic [183:0]  inp_r;
  logic          found_r;
  logic [IW-1:0] tgt_r;
  logic [15:0]   minv_r;
  logic [6:0]    live_r;
  logic          zero_r;
  logic [15:0]   rem_r;
  logic [20:0]   sh_r;
  logic [20:0]   quo_r;
  logic [21:0]   y_r;
  logic [16:0]   m_r;
  logic [167:0]  odata_r;
  logic          ouser_r;
  logic          olast_r;

  logic [15:0] dval;
  logic [31:0] dt;
  logic [16:0] div_t;
  logic        div_ge;
  logic [37:0] prod_y;
  logic [16:0] t_lo, t_hi;
  logic [27:0] prod_d;
  logic [32:0] prod_v;
  logic [15:0] v_sh;
  logic [15:0] v_new;
  logic [31:0] in_col;
  logic [IW-1:0] oidx;

  assign dval   = (decay_r == 16'd0) ? 16'd1 : decay_r;
  assign dt     = inp_r[175:144] - st_time_r[idx];
  assign div_t  = {rem_r, sh_r[20]};
  assign div_ge = (div_t >= {1'b0, dval});
  assign prod_y = quo_r * dhst_pkg::LOG2E_Q16;
  assign t_lo   = dhst_pkg::pow2_q16({1'b0, y_r[15:12]});
  assign t_hi   = dhst_pkg::pow2_q16(5'({1'b0, y_r[15:12]} + 5'd1));
  assign prod_d = 16'(t_lo - t_hi) * y_r[11:0];
  assign prod_v = start_lv_r[idx] * m_r;
  assign v_sh   = prod_v[31:16] >> y_r[19:16];
  assign v_new  = (zero_r || (y_r[21:16] >= 6'd16)) ? 16'd0 : v_sh;
  assign in_col = (inp_r[127:96] == 32'd0) ? fallback_r : inp_r[127:96];
  assign oidx   = cmd.out_push ? tgt_r : idx;
  assign sts.skip = (start_lv_r[idx] == 16'd0);

  assign out_tdata = odata_r;
  assign out_tuser = ouser_r;
  assign out_tlast = olast_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decay_r    <= 16'd1000;
      fallback_r <= 32'hFFFF_FFFF;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        dhst_pkg::CFG_DECAY:    decay_r    <= cfg_wdata[15:0];
        dhst_pkg::CFG_FALLBACK: fallback_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < SLOTS; k++) begin
        start_lv_r[k] <= '0;
        cur_lv_r[k]   <= '0;
        st_time_r[k]  <= '0;
        col_r[k]      <= '0;
        px_r[k]       <= '0;
        py_r[k]       <= '0;
        pz_r[k]       <= '0;
        tex_r[k]      <= '0;
      end
    end else if (cmd.push_wr) begin
      start_lv_r[tgt_r] <= inp_r[143:128];
      cur_lv_r[tgt_r]   <= inp_r[143:128];
      st_time_r[tgt_r]  <= inp_r[175:144];
      col_r[tgt_r]      <= in_col;
      px_r[tgt_r]       <= inp_r[31:0];
      py_r[tgt_r]       <= inp_r[63:32];
      pz_r[tgt_r]       <= inp_r[95:64];
      tex_r[tgt_r]      <= inp_r[183:176];
    end else if (cmd.tick_wr) begin
      if (v_new < dhst_pkg::THRESH) begin
        cur_lv_r[idx]   <= '0;
        start_lv_r[idx] <= '0;
      end else begin
        cur_lv_r[idx] <= v_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) inp_r <= in_tdata;
    if (cmd.scan_clr) begin
      found_r <= 1'b0;
      tgt_r   <= '0;
      minv_r  <= cur_lv_r[0];
    end else if (cmd.scan_step && !found_r) begin
      if (cur_lv_r[idx] < dhst_pkg::THRESH) begin
        found_r <= 1'b1;
        tgt_r   <= idx;
      end else if (cur_lv_r[idx] < minv_r) begin
        minv_r <= cur_lv_r[idx];
        tgt_r  <= idx;
      end
    end
    if (cmd.cnt_clr) live_r <= '0;
    else if (cmd.cnt_step && cur_lv_r[idx] >= dhst_pkg::THRESH) live_r <= live_r + 7'd1;
    if (cmd.tick_init) begin
      zero_r <= (dt >= {11'd0, dval, 5'd0});
      rem_r  <= dt[20:5];
      sh_r   <= {dt[4:0], 16'd0};
      quo_r  <= '0;
    end else if (cmd.div_step) begin
      rem_r <= div_ge ? 16'(div_t - {1'b0, dval}) : div_t[15:0];
      sh_r  <= {sh_r[19:0], 1'b0};
      quo_r <= {quo_r[19:0], div_ge};
    end
    if (cmd.mul_y) y_r <= prod_y[37:16];
    if (cmd.mul_m) m_r <= t_lo - 17'(prod_d[27:12]);
    if (cmd.out_load) begin
      odata_r <= {3'd0, live_r, tex_r[oidx], pz_r[oidx], py_r[oidx], px_r[oidx],
                  col_r[oidx], cur_lv_r[oidx], 6'(oidx)};
      ouser_r <= cmd.out_push && !found_r;
      olast_r <= cmd.out_last;
    end
  end

endmodule

@@ sv/decaying_hit_slot_table.sv @@
// Push: after accept the slot scan, write, live count walk and load run, then out_tvalid rises.
// Tick: each live slot runs setup, a 21-step divider, two multiply stages and write-back;
// a retired slot only passes setup; then a count walk, and a load and send per emitted result.
// One transaction in flight at a time; the next input is taken after the last result.
// rst_n is synchronous, active low; all slots clear, decay_ms=1000, fallback=all ones.
module decaying_hit_slot_table #(
  parameter int SLOTS = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic         cfg_addr,
  input  logic [31:0]  cfg_wdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  // pos_x, pos_y, pos_z, hit_color, strength, now_ms, tex_id
  input  logic [183:0] in_tdata,
  // op
  input  logic         in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // slot, level, slot_color, slot_x, slot_y, slot_z, slot_tex, live_count, pad
  output logic [167:0] out_tdata,
  // evicted
  output logic         out_tuser,
  output logic         out_tlast
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  dhst_pkg::cmd_t cmd;
  dhst_pkg::sts_t sts;
  logic [IW-1:0]  idx;

  dhst_ctrl #(.SLOTS(SLOTS), .IW(IW)) u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_op(in_tuser), .in_tready(in_tready),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .sts(sts), .cmd(cmd), .idx(idx)
  );

  dhst_dp #(.SLOTS(SLOTS), .IW(IW)) u_dp (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .in_tdata(in_tdata), .cmd(cmd), .idx(idx), .sts(sts),
    .out_tdata(out_tdata), .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

endmodule

@@ sv/dhst_checker.sv @@
module dhst_checker #(
  parameter int SLOTS = 8
) (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [167:0] out_tdata,
  input logic         out_tuser,
  input logic         out_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input taken while a result is pending");

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ({1'b0, out_tdata[5:0]} < 7'(SLOTS)) && (out_tdata[164:158] <= 7'(SLOTS)))
    else $error("slot or live count out of range");

  a_evict_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("evicted flag on a non-final result");

endmodule

bind decaying_hit_slot_table dhst_checker #(.SLOTS(SLOTS)) u_dhst_checker (
  .clk(clk), .rst_n(rst_n),
  .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready),
  .out_tdata(out_tdata), .out_tuser(out_tuser), .out_tlast(out_tlast)
);
